// ===== rtl/core/gtec_pkg.sv =====
`timescale 1ns / 1ps

package gtec_pkg;

	localparam int EVT_W    = 9;
	localparam int PORT_BIT = 8;
	localparam int CH_W     = 3;
	localparam int PIN_W    = 5;

	typedef enum logic [3:0] {
		CMD_TASK_OUT     = 4'd0,
		CMD_TASK_SET     = 4'd1,
		CMD_TASK_CLR     = 4'd2,
		CMD_PIN_CHANGE   = 4'd3,
		CMD_PORT_DETECT  = 4'd4,
		CMD_WRITE_CONFIG = 4'd5,
		CMD_INTEN_SET    = 4'd6,
		CMD_INTEN_CLR    = 4'd7,
		CMD_CLEAR_EVENTS = 4'd8
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_DISABLED = 2'd0,
		MODE_EVENT    = 2'd1,
		MODE_TASK     = 2'd2,
		MODE_ILLEGAL  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		POL_NONE   = 2'd0,
		POL_RISE   = 2'd1,
		POL_FALL   = 2'd2,
		POL_TOGGLE = 2'd3
	} pol_t;

	typedef struct packed {
		cmd_t             command;
		logic [CH_W-1:0]  channel;
		logic             pin_value;
		mode_t            cfg_mode;
		pol_t             cfg_polarity;
		logic             cfg_outinit;
		logic [PIN_W-1:0] cfg_pin;
		logic             cfg_port;
		logic [EVT_W-1:0] mask;
	} item_t;

	typedef struct packed {
		logic             drive_valid;
		logic             drive_port;
		logic [PIN_W-1:0] drive_pin;
		logic             drive_level;
		logic [EVT_W-1:0] pulse;
	} chan_res_t;

endpackage

// ===== rtl/core/gtec_chan.sv =====
`timescale 1ns / 1ps

module gtec_chan import gtec_pkg::*; #(
	parameter int CHANNELS = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  item_t     item,
	output chan_res_t res
);

	localparam int IDXW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [CH_W:0] CH_LIMIT = (CH_W + 1)'(CHANNELS);

	mode_t            mode_q   [CHANNELS];
	pol_t             pol_q    [CHANNELS];
	logic [PIN_W-1:0] pin_q    [CHANNELS];
	logic             port_q   [CHANNELS];
	logic             level_q  [CHANNELS];

	logic             ch_ok;
	logic [IDXW-1:0]  idx;
	mode_t            cur_mode;
	pol_t             cur_pol;
	logic             cur_level;
	logic             cfg_wr;
	logic             level_wr;
	logic             level_nxt;
	logic             hit;

	always_comb begin
		ch_ok     = {1'b0, item.channel} < CH_LIMIT;
		idx       = ch_ok ? item.channel[IDXW-1:0] : '0;
		cur_mode  = mode_q[idx];
		cur_pol   = pol_q[idx];
		cur_level = level_q[idx];
		cfg_wr    = 1'b0;
		level_wr  = 1'b0;
		level_nxt = cur_level;
		hit       = 1'b0;
		res       = '0;
		case (item.command)
			CMD_TASK_OUT: begin
				if (ch_ok && cur_mode == MODE_TASK && cur_pol != POL_NONE) begin
					level_wr = 1'b1;
					case (cur_pol)
						POL_RISE: level_nxt = 1'b1;
						POL_FALL: level_nxt = 1'b0;
						default:  level_nxt = ~cur_level;
					endcase
					res.drive_valid = 1'b1;
				end
			end
			CMD_TASK_SET, CMD_TASK_CLR: begin
				if (ch_ok && cur_mode == MODE_TASK) begin
					level_wr        = 1'b1;
					level_nxt       = (item.command == CMD_TASK_SET);
					res.drive_valid = 1'b1;
				end
			end
			CMD_PIN_CHANGE: begin
				if (ch_ok && cur_mode == MODE_EVENT && cur_pol != POL_NONE) begin
					case (cur_pol)
						POL_RISE: hit = !cur_level && item.pin_value;
						POL_FALL: hit = cur_level && !item.pin_value;
						default:  hit = cur_level != item.pin_value;
					endcase
					level_wr  = 1'b1;
					level_nxt = item.pin_value;
					if (hit) begin
						res.pulse = EVT_W'(1) << item.channel;
					end
				end
			end
			CMD_PORT_DETECT: begin
				res.pulse = EVT_W'(1) << PORT_BIT;
			end
			CMD_WRITE_CONFIG: begin
				if (ch_ok) begin
					cfg_wr = 1'b1;
					if (item.cfg_mode == MODE_EVENT) begin
						level_wr  = 1'b1;
						level_nxt = item.pin_value;
					end else if (item.cfg_mode == MODE_TASK) begin
						level_wr        = 1'b1;
						level_nxt       = item.cfg_outinit;
						res.drive_valid = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
		if (res.drive_valid) begin
			res.drive_level = level_nxt;
			res.drive_port  = cfg_wr ? item.cfg_port : port_q[idx];
			res.drive_pin   = cfg_wr ? item.cfg_pin : pin_q[idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				mode_q[i]  <= MODE_DISABLED;
				pol_q[i]   <= POL_NONE;
				pin_q[i]   <= '0;
				port_q[i]  <= 1'b0;
				level_q[i] <= 1'b0;
			end
		end else if (en) begin
			if (cfg_wr) begin
				mode_q[idx] <= item.cfg_mode;
				pol_q[idx]  <= item.cfg_polarity;
				pin_q[idx]  <= item.cfg_pin;
				port_q[idx] <= item.cfg_port;
			end
			if (level_wr) begin
				level_q[idx] <= level_nxt;
			end
		end
	end

endmodule

// ===== rtl/core/gtec_irq.sv =====
`timescale 1ns / 1ps

module gtec_irq import gtec_pkg::*; #(
	parameter int CHANNELS = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  cmd_t             command,
	input  logic [EVT_W-1:0] mask,
	input  logic [EVT_W-1:0] pulse,
	output logic [EVT_W-1:0] flags,
	output logic             irq
);

	localparam logic [EVT_W-1:0] VALID_MASK =
		EVT_W'((1 << CHANNELS) - 1) | (EVT_W'(1) << PORT_BIT);

	logic [EVT_W-1:0] pending_q;
	logic [EVT_W-1:0] enable_q;
	logic [EVT_W-1:0] enable_nxt;

	always_comb begin
		enable_nxt = enable_q;
		flags      = pending_q;
		case (command)
			CMD_INTEN_SET:    enable_nxt = (enable_q | mask) & VALID_MASK;
			CMD_INTEN_CLR:    enable_nxt = enable_q & ~mask;
			CMD_CLEAR_EVENTS: flags      = pending_q & ~mask;
			default: begin
			end
		endcase
		flags = flags | pulse;
		irq   = |(flags & enable_nxt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			enable_q  <= '0;
		end else if (en) begin
			pending_q <= flags;
			enable_q  <= enable_nxt;
		end
	end

endmodule

// ===== rtl/core/gpio_task_event_channels_unit.sv =====
`timescale 1ns / 1ps
// Each word passes the input register, then the result register, to the output.
// Throughput: one word per cycle; the input register and the result register each
// hold one word, and a stalled output holds back the input only when both are full.
// Reset: arst_n clears all channel settings, levels, pending events and interrupt
// enables to zero, and empties both registers.

module gpio_task_event_channels_unit import gtec_pkg::*; #(
	parameter int CHANNELS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// channel, pin_value, cfg_mode, cfg_polarity, cfg_outinit, cfg_pin, cfg_port, mask
	input  logic [23:0] s_tdata,
	// command
	input  logic [3:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// drive_valid, drive_port, drive_pin, drive_level, event_pulse, event_flags,
	// irq_line, zero fill
	output logic [31:0] m_tdata
);

	item_t            item_in;
	item_t            item_s1;
	logic             valid_s1;
	logic             advance;
	chan_res_t        chan_res;
	logic [EVT_W-1:0] flags;
	logic             irq;

	logic             out_valid_q;
	chan_res_t        res_q;
	logic [EVT_W-1:0] flags_q;
	logic             irq_q;

	always_comb begin
		item_in.command      = cmd_t'(s_tuser);
		item_in.channel      = s_tdata[2:0];
		item_in.pin_value    = s_tdata[3];
		item_in.cfg_mode     = mode_t'(s_tdata[5:4]);
		item_in.cfg_polarity = pol_t'(s_tdata[7:6]);
		item_in.cfg_outinit  = s_tdata[8];
		item_in.cfg_pin      = s_tdata[13:9];
		item_in.cfg_port     = s_tdata[14];
		item_in.mask         = s_tdata[23:15];
	end

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= item_in;
		end
	end

	gtec_chan #(
		.CHANNELS(CHANNELS)
	) u_chan (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.item   (item_s1),
		.res    (chan_res)
	);

	gtec_irq #(
		.CHANNELS(CHANNELS)
	) u_irq (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (advance),
		.command (item_s1.command),
		.mask    (item_s1.mask),
		.pulse   (chan_res.pulse),
		.flags   (flags),
		.irq     (irq)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q   <= chan_res;
			flags_q <= flags;
			irq_q   <= irq;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, irq_q, flags_q, res_q.pulse, res_q.drive_level,
		res_q.drive_pin, res_q.drive_port, res_q.drive_valid};

	a_pulse_pending: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[16:8] & ~m_tdata[25:17]) == '0))
		else $error("raised event missing from pending flags");

	a_pulse_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $onehot0(m_tdata[16:8]))
		else $error("more than one event raised by one word");

	a_drive_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[0]) |-> (m_tdata[7:1] == '0))
		else $error("drive fields set without a drive");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !m_tvalid) |=> m_tvalid)
		else $error("held word did not move to the result register");

endmodule

// ===== sim/gpio_task_event_channels_unit_tb.sv =====
`timescale 1ns / 1ps

module gpio_task_event_channels_unit_tb;
	import gtec_pkg::*;

	localparam int CHANNELS = 8;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 10;
	localparam logic [EVT_W-1:0] VALID_EVENTS = EVT_W'((1 << PORT_BIT) | ((1 << CHANNELS) - 1));

	// Result word as it sits in m_tdata, drive_valid in the lowest bit.
	typedef struct packed {
		logic             irq_line;
		logic [EVT_W-1:0] event_flags;
		logic [EVT_W-1:0] event_pulse;
		logic             drive_level;
		logic [PIN_W-1:0] drive_pin;
		logic             drive_port;
		logic             drive_valid;
	} gpio_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic [3:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;

	gpio_task_event_channels_unit #(.CHANNELS(CHANNELS)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	// Channel state as the block should hold it.
	mode_t            ch_mode [CHANNELS];
	pol_t             ch_pol [CHANNELS];
	logic [PIN_W-1:0] ch_pin [CHANNELS];
	logic             ch_port [CHANNELS];
	logic             ch_level [CHANNELS];
	logic [EVT_W-1:0] pending_flags;
	logic [EVT_W-1:0] irq_enables;

	item_t      command_queue[$];
	gpio_word_t expected_words[$];
	item_t      current_cmd;
	int         n_total = 0;
	int         n_sent = 0;
	int         send_idle = 18;
	int         recv_idle = 74;
	int         n_errors = 0;
	int         quiet_cycles = 0;

	function automatic gpio_word_t gpio_predict(item_t it);
		gpio_word_t w;
		logic [CH_W-1:0] ch;
		logic drive;
		logic hit;
		logic [EVT_W-1:0] pulse;
		ch = it.channel;
		drive = 1'b0;
		hit = 1'b0;
		pulse = '0;
		w = '0;
		case (it.command)
			CMD_TASK_OUT: begin
				if (int'(ch) < CHANNELS && ch_mode[ch] == MODE_TASK && ch_pol[ch] != POL_NONE) begin
					if (ch_pol[ch] == POL_RISE)
						ch_level[ch] = 1'b1;
					else if (ch_pol[ch] == POL_FALL)
						ch_level[ch] = 1'b0;
					else
						ch_level[ch] = ~ch_level[ch];
					drive = 1'b1;
				end
			end
			CMD_TASK_SET, CMD_TASK_CLR: begin
				if (int'(ch) < CHANNELS && ch_mode[ch] == MODE_TASK) begin
					ch_level[ch] = (it.command == CMD_TASK_SET);
					drive = 1'b1;
				end
			end
			CMD_PIN_CHANGE: begin
				if (int'(ch) < CHANNELS && ch_mode[ch] == MODE_EVENT && ch_pol[ch] != POL_NONE) begin
					if (ch_pol[ch] == POL_RISE)
						hit = !ch_level[ch] && it.pin_value;
					else if (ch_pol[ch] == POL_FALL)
						hit = ch_level[ch] && !it.pin_value;
					else
						hit = ch_level[ch] != it.pin_value;
					ch_level[ch] = it.pin_value;
					if (hit)
						pulse[ch] = 1'b1;
				end
			end
			CMD_PORT_DETECT: pulse[PORT_BIT] = 1'b1;
			CMD_WRITE_CONFIG: begin
				if (int'(ch) < CHANNELS) begin
					ch_mode[ch] = it.cfg_mode;
					ch_pol[ch] = it.cfg_polarity;
					ch_pin[ch] = it.cfg_pin;
					ch_port[ch] = it.cfg_port;
					if (it.cfg_mode == MODE_EVENT) begin
						ch_level[ch] = it.pin_value;
					end else if (it.cfg_mode == MODE_TASK) begin
						ch_level[ch] = it.cfg_outinit;
						drive = 1'b1;
					end
				end
			end
			CMD_INTEN_SET: irq_enables = (irq_enables | it.mask) & VALID_EVENTS;
			CMD_INTEN_CLR: irq_enables = irq_enables & ~it.mask;
			CMD_CLEAR_EVENTS: pending_flags = pending_flags & ~it.mask;
			default: ;
		endcase
		pending_flags = pending_flags | pulse;
		if (drive) begin
			w.drive_valid = 1'b1;
			w.drive_port = ch_port[ch];
			w.drive_pin = ch_pin[ch];
			w.drive_level = ch_level[ch];
		end
		w.event_pulse = pulse;
		w.event_flags = pending_flags;
		w.irq_line = |(pending_flags & irq_enables);
		return w;
	endfunction

	function automatic item_t make_cmd(cmd_t cmd, int ch, bit pv, mode_t mode, pol_t pol,
			bit outinit, int pin, bit port, int mask);
		item_t it;
		it.command = cmd;
		it.channel = CH_W'(ch);
		it.pin_value = pv;
		it.cfg_mode = mode;
		it.cfg_polarity = pol;
		it.cfg_outinit = outinit;
		it.cfg_pin = PIN_W'(pin);
		it.cfg_port = port;
		it.mask = EVT_W'(mask);
		return it;
	endfunction

	function automatic item_t random_cmd();
		item_t it;
		int pick;
		it.channel = CH_W'($urandom_range(CHANNELS - 1));
		it.pin_value = 1'($urandom_range(1));
		it.cfg_mode = mode_t'($urandom_range(3));
		it.cfg_polarity = pol_t'($urandom_range(3));
		it.cfg_outinit = 1'($urandom_range(1));
		it.cfg_pin = PIN_W'($urandom_range(31));
		it.cfg_port = 1'($urandom_range(1));
		it.mask = EVT_W'($urandom_range(511));
		pick = $urandom_range(99);
		if (pick < 15) begin
			it.command = CMD_WRITE_CONFIG;
			pick = $urandom_range(9);
			if (pick < 4)
				it.cfg_mode = MODE_EVENT;
			else if (pick < 8)
				it.cfg_mode = MODE_TASK;
		end else if (pick < 25) begin
			it.command = CMD_TASK_OUT;
		end else if (pick < 32) begin
			it.command = CMD_TASK_SET;
		end else if (pick < 39) begin
			it.command = CMD_TASK_CLR;
		end else if (pick < 69) begin
			it.command = CMD_PIN_CHANGE;
		end else if (pick < 74) begin
			it.command = CMD_PORT_DETECT;
		end else if (pick < 81) begin
			it.command = CMD_INTEN_SET;
		end else if (pick < 87) begin
			it.command = CMD_INTEN_CLR;
		end else if (pick < 95) begin
			it.command = CMD_CLEAR_EVENTS;
		end else begin
			it.command = cmd_t'(4'($urandom_range(15, 9)));
		end
		return it;
	endfunction

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		for (int i = 0; i < CHANNELS; i++) begin
			ch_mode[i] = MODE_DISABLED;
			ch_pol[i] = POL_NONE;
			ch_pin[i] = '0;
			ch_port[i] = 1'b0;
			ch_level[i] = 1'b0;
		end
		pending_flags = '0;
		irq_enables = '0;

		// Commands against unconfigured channels do nothing.
		command_queue.push_back(make_cmd(CMD_TASK_OUT, 0, 0, MODE_DISABLED, POL_NONE, 0, 0, 0, 0));
		command_queue.push_back(make_cmd(CMD_PIN_CHANGE, 1, 1, MODE_DISABLED, POL_NONE, 0, 0, 0, 0));
		// Task channels with every polarity.
		command_queue.push_back(make_cmd(CMD_WRITE_CONFIG, 0, 0, MODE_TASK, POL_TOGGLE, 1, 31, 1, 0));
		command_queue.push_back(make_cmd(CMD_TASK_OUT, 0, 0, MODE_DISABLED, POL_NONE, 0, 0, 0, 0));
		command_queue.push_back(make_cmd(CMD_TASK_SET, 0, 0, MODE_DISABLED, POL_NONE, 0, 0, 0, 0));
		command_queue.push_back(make_cmd(CMD_TASK_CLR, 0, 0, MODE_DISABLED, POL_NONE, 0, 0, 0, 0));
		command_queue.push_back(make_cmd(CMD_WRITE_CONFIG, 1, 1, MODE_TASK, POL_NONE, 0, 0, 0, 0));
		command_queue.push_back(make_cmd(CMD_TASK_OUT, 1, 0, MODE_DISABLED, POL_NONE, 0, 0, 0, 0));
		command_queue.push_back(make_cmd(CMD_WRITE_CONFIG, 2, 0, MODE_TASK, POL_RISE, 0, 7, 0, 0));
		command_queue.push_back(make_cmd(CMD_TASK_OUT, 2, 0, MODE_DISABLED, POL_NONE, 0, 0, 0, 0));
		command_queue.push_back(make_cmd(CMD_WRITE_CONFIG, 3, 0, MODE_TASK, POL_FALL, 1, 16, 1, 0));
		command_queue.push_back(make_cmd(CMD_TASK_OUT, 3, 0, MODE_DISABLED, POL_NONE, 0, 0, 0, 0));
		// Event channels with every polarity, repeated events included.
		command_queue.push_back(make_cmd(CMD_WRITE_CONFIG, 4, 0, MODE_EVENT, POL_RISE, 0, 4, 0, 0));
		command_queue.push_back(make_cmd(CMD_PIN_CHANGE, 4, 1, MODE_DISABLED, POL_NONE, 0, 0, 0, 0));
		command_queue.push_back(make_cmd(CMD_PIN_CHANGE, 4, 1, MODE_DISABLED, POL_NONE, 0, 0, 0, 0));
		command_queue.push_back(make_cmd(CMD_WRITE_CONFIG, 5, 1, MODE_EVENT, POL_FALL, 1, 5, 1, 0));
		command_queue.push_back(make_cmd(CMD_PIN_CHANGE, 5, 0, MODE_DISABLED, POL_NONE, 0, 0, 0, 0));
		command_queue.push_back(make_cmd(CMD_WRITE_CONFIG, 6, 0, MODE_EVENT, POL_TOGGLE, 0, 6, 0, 0));
		command_queue.push_back(make_cmd(CMD_PIN_CHANGE, 6, 1, MODE_DISABLED, POL_NONE, 0, 0, 0, 0));
		command_queue.push_back(make_cmd(CMD_PIN_CHANGE, 6, 0, MODE_DISABLED, POL_NONE, 0, 0, 0, 0));
		command_queue.push_back(make_cmd(CMD_WRITE_CONFIG, 7, 0, MODE_EVENT, POL_NONE, 0, 9, 0, 0));
		command_queue.push_back(make_cmd(CMD_PIN_CHANGE, 7, 1, MODE_DISABLED, POL_NONE, 0, 0, 0, 0));
		command_queue.push_back(make_cmd(CMD_WRITE_CONFIG, 7, 1, MODE_ILLEGAL, POL_TOGGLE, 1, 31, 1, 0));
		command_queue.push_back(make_cmd(CMD_TASK_SET, 7, 0, MODE_DISABLED, POL_NONE, 0, 0, 0, 0));
		command_queue.push_back(make_cmd(CMD_PORT_DETECT, 0, 0, MODE_DISABLED, POL_NONE, 0, 0, 0, 0));
		command_queue.push_back(make_cmd(CMD_INTEN_SET, 0, 0, MODE_DISABLED, POL_NONE, 0, 0, 0, 511));
		command_queue.push_back(make_cmd(CMD_INTEN_CLR, 0, 0, MODE_DISABLED, POL_NONE, 0, 0, 0, 255));
		command_queue.push_back(make_cmd(CMD_CLEAR_EVENTS, 0, 0, MODE_DISABLED, POL_NONE, 0, 0, 0, 511));
		command_queue.push_back(make_cmd(cmd_t'(4'd9), 0, 1, MODE_TASK, POL_RISE, 1, 3, 1, 511));
		command_queue.push_back(make_cmd(cmd_t'(4'd15), 2, 1, MODE_EVENT, POL_FALL, 0, 3, 1, 511));
		for (int i = 0; i < 500; i++)
			command_queue.push_back(random_cmd());
		n_total = command_queue.size();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (command_queue.size() != 0 || s_tvalid || expected_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_words.push_back(gpio_predict(current_cmd));
				n_sent++;
				if (n_sent >= 2 * n_total / 3) begin
					send_idle <= 0;
					recv_idle <= 0;
				end else if (n_sent >= n_total / 3) begin
					send_idle <= 74;
					recv_idle <= 18;
				end
			end
			if (!s_tvalid || s_tready) begin
				if (command_queue.size() != 0 && $urandom_range(99) >= send_idle) begin
					current_cmd = command_queue.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= current_cmd.command;
					s_tdata <= {current_cmd.mask, current_cmd.cfg_port, current_cmd.cfg_pin,
						current_cmd.cfg_outinit, current_cmd.cfg_polarity, current_cmd.cfg_mode,
						current_cmd.pin_value, current_cmd.channel};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		gpio_word_t got;
		gpio_word_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[26:0];
				if (expected_words.size() == 0) begin
					n_errors++;
					if (n_errors <= 10)
						$display("Unexpected result word %h.", m_tdata);
				end else begin
					want = expected_words.pop_front();
					if (got.drive_valid !== want.drive_valid || got.drive_port !== want.drive_port
							|| got.drive_pin !== want.drive_pin
							|| got.drive_level !== want.drive_level
							|| got.event_pulse !== want.event_pulse
							|| got.event_flags !== want.event_flags
							|| got.irq_line !== want.irq_line) begin
						n_errors++;
						if (n_errors <= 10) begin
							$display("Mismatch: expected drive %b port %b pin %0d level %b pulse %h flags %h irq %b,",
								want.drive_valid, want.drive_port, want.drive_pin,
								want.drive_level, want.event_pulse, want.event_flags,
								want.irq_line);
							$display("  got drive %b port %b pin %0d level %b pulse %h flags %h irq %b.",
								got.drive_valid, got.drive_port, got.drive_pin,
								got.drive_level, got.event_pulse, got.event_flags, got.irq_line);
						end
					end
				end
			end
			m_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

endmodule
